>>> rtl/core/prq_pkg.sv
`timescale 1ns / 1ps

package prq_pkg;

  // Default sizing of the queue
  localparam int MAX_TASKS_DEF     = 16;
  localparam int PRIORITY_BITS_DEF = 8;

  // Fixed field widths of the transaction ports
  localparam int ACTION_W   = 3;
  localparam int TASK_W     = 4;
  localparam int PRIO_REQ_W = 8;
  localparam int LEN_W      = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SETTINGS = 3'd0,
    ACT_ENQUEUE  = 3'd1,
    ACT_REMOVE   = 3'd2,
    ACT_CHANGE   = 3'd3,
    ACT_TICK     = 3'd4
  } action_t;

  // Operation applied to the whole row of slot cells together
  typedef struct packed {
    logic remove;
    logic insert;
  } cell_op_t;

  // Write strobes and flag data for the per-task settings table
  typedef struct packed {
    logic prio_we;
    logic rr_we;
    logic queued_we;
    logic rr;
    logic queued;
  } tab_wr_t;

endpackage

>>> rtl/core/prq_cell.sv
`timescale 1ns / 1ps

// One queue slot. A remove pulls the right-hand neighbour in from the matching
// slot onward; an insert pushes the row right from the first empty or lower-priority slot.
module prq_cell #(
  parameter int PRIORITY_BITS = prq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  prq_pkg::cell_op_t           op,
  input  logic [prq_pkg::TASK_W-1:0]  key_task,
  input  logic [prq_pkg::TASK_W-1:0]  ins_task,
  input  logic [PRIORITY_BITS-1:0]    ins_prio,
  input  logic                        prev_valid,
  input  logic                        prev_keep,
  input  logic [prq_pkg::TASK_W-1:0]  prev_task,
  input  logic [PRIORITY_BITS-1:0]    prev_prio,
  input  logic                        found_in,
  input  logic                        next_valid,
  input  logic [prq_pkg::TASK_W-1:0]  next_task,
  input  logic [PRIORITY_BITS-1:0]    next_prio,
  output logic                        slot_valid,
  output logic [prq_pkg::TASK_W-1:0]  slot_task,
  output logic [PRIORITY_BITS-1:0]    slot_prio,
  output logic                        keep,
  output logic                        found_out,
  output logic                        valid_next,
  output logic [prq_pkg::TASK_W-1:0]  task_next
);

  logic                     hit;
  logic [PRIORITY_BITS-1:0] prio_next;

  assign hit       = slot_valid && (slot_task == key_task);
  assign found_out = found_in || hit;
  // Hold position when this slot is served ahead of the incoming task
  assign keep      = slot_valid && (slot_prio >= ins_prio);

  always_comb begin
    valid_next = slot_valid;
    task_next  = slot_task;
    prio_next  = slot_prio;
    if (op.remove && found_out) begin
      valid_next = next_valid;
      task_next  = next_task;
      prio_next  = next_prio;
    end else if (op.insert && !keep) begin
      if (prev_keep) begin
        valid_next = 1'b1;
        task_next  = ins_task;
        prio_next  = ins_prio;
      end else begin
        valid_next = prev_valid;
        task_next  = prev_task;
        prio_next  = prev_prio;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else begin
      slot_valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    slot_task <= task_next;
    slot_prio <= prio_next;
  end

endmodule

>>> rtl/core/prq_tab.sv
`timescale 1ns / 1ps

// Per-task settings: priority, round-robin flag and queued flag.
module prq_tab #(
  parameter int ID_COUNT      = prq_pkg::MAX_TASKS_DEF,
  parameter int PRIORITY_BITS = prq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  prq_pkg::tab_wr_t            wr,
  input  logic [$clog2(ID_COUNT)-1:0] idx,
  input  logic [PRIORITY_BITS-1:0]    wr_prio,
  output logic [PRIORITY_BITS-1:0]    rd_prio,
  output logic                        rd_rr,
  output logic                        rd_queued,
  output logic [ID_COUNT-1:0]         queued_vec
);

  logic [PRIORITY_BITS-1:0] prio_mem [ID_COUNT];
  logic [ID_COUNT-1:0]      rr_vec;

  assign rd_prio   = prio_mem[idx];
  assign rd_rr     = rr_vec[idx];
  assign rd_queued = queued_vec[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ID_COUNT; i++) begin
        prio_mem[i] <= '0;
      end
      rr_vec     <= '0;
      queued_vec <= '0;
    end else begin
      if (wr.prio_we) begin
        prio_mem[idx] <= wr_prio;
      end
      if (wr.rr_we) begin
        rr_vec[idx] <= wr.rr;
      end
      if (wr.queued_we) begin
        queued_vec[idx] <= wr.queued;
      end
    end
  end

endmodule

>>> rtl/core/priority_ready_queue.sv
`timescale 1ns / 1ps

// Priority ready queue of task ids, highest priority at the head, first in
// first out among equal priorities.
// Input channel (item_valid / item_ready): one transaction carries action,
// task_id, priority_req and round_robin. Output channel (result_valid /
// result_ready): one transaction per input transaction, in order, with the
// head task (0 when empty), the queue length and a rejected flag.
// Timing: a transaction is taken in the idle cycle, the slot row does a
// remove pass in the next cycle and an insert pass in the one after, where
// the result register loads once it is free. A new transaction is taken
// only once the last one has loaded its result; the two shift passes over
// the row of slot cells set the pace.
// Stall: a result waiting on result_ready does not block the next input
// transaction; only the following result waits for the output register.
// Reset: all slots empty, all task priorities and flags cleared, no result
// pending; item_ready is held low during reset and rises as soon as rst falls.
module priority_ready_queue #(
  parameter int MAX_TASKS     = prq_pkg::MAX_TASKS_DEF,
  parameter int PRIORITY_BITS = prq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic [prq_pkg::ACTION_W-1:0]    action,
  input  logic [prq_pkg::TASK_W-1:0]      task_id,
  input  logic [prq_pkg::PRIO_REQ_W-1:0]  priority_req,
  input  logic                            round_robin,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [prq_pkg::TASK_W-1:0]      current_task,
  output logic [prq_pkg::LEN_W-1:0]       queue_length,
  output logic                            rejected
);

  localparam int SLOTS    = MAX_TASKS - 1;
  // Only ids that fit the task_id field can ever be named
  localparam int ID_COUNT = (MAX_TASKS < (1 << prq_pkg::TASK_W)) ?
                            MAX_TASKS : (1 << prq_pkg::TASK_W);
  localparam int IDX_W    = $clog2(ID_COUNT);
  localparam int CNT_W    = $clog2(MAX_TASKS);
  localparam int TW       = prq_pkg::TASK_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REMOVE,
    S_INSERT,
    S_HOLD
  } state_t;

  state_t state;

  // Held transaction
  prq_pkg::action_t          item_action;
  logic [TW-1:0]             item_task;
  logic [PRIORITY_BITS-1:0]  item_prio;
  logic                      item_rr;

  // Pending insert, carried from the remove pass to the insert pass
  logic                      ins_pending;
  logic [TW-1:0]             ins_task;
  logic [PRIORITY_BITS-1:0]  ins_prio;
  logic                      bad_q;

  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;

  // Slot row
  logic [SLOTS-1:0]          c_valid;
  logic [SLOTS-1:0]          c_keep;
  logic [SLOTS-1:0]          c_found;
  logic [SLOTS-1:0]          c_valid_next;
  logic [TW-1:0]             c_task      [SLOTS];
  logic [TW-1:0]             c_task_next [SLOTS];
  logic [PRIORITY_BITS-1:0]  c_prio      [SLOTS];
  prq_pkg::cell_op_t         cell_op;

  // Decode of the held transaction
  logic                      bad;
  logic                      do_remove;
  logic                      do_insert;
  logic [TW-1:0]             key_task;
  logic [TW-1:0]             ins_task_d;
  logic [PRIORITY_BITS-1:0]  ins_prio_d;
  logic                      id_bad;
  logic                      full;
  logic                      head_valid;
  logic [TW-1:0]             head_task;
  logic                      res_load;

  // Settings table
  prq_pkg::tab_wr_t          tab_wr;
  prq_pkg::tab_wr_t          tab_wr_d;
  logic [IDX_W-1:0]          tab_idx;
  logic [PRIORITY_BITS-1:0]  rd_prio;
  logic                      rd_rr;
  logic                      rd_queued;
  logic [ID_COUNT-1:0]       queued_vec;

  assign item_ready = (state == S_IDLE) && !rst;
  assign head_valid = c_valid[0];
  assign head_task  = c_task[0];
  assign full       = (int'(count) >= SLOTS);
  assign id_bad     = (item_action <= prq_pkg::ACT_CHANGE) &&
                      ((item_task == '0) || (int'(item_task) >= ID_COUNT));
  // Load the result register once the insert pass is done and it is free
  assign res_load   = (state inside {S_INSERT, S_HOLD}) &&
                      (!result_valid || result_ready);

  // A tick looks up the head task, every other action the named task
  assign tab_idx = (item_action == prq_pkg::ACT_TICK) ? head_task[IDX_W-1:0] :
                                                        item_task[IDX_W-1:0];

  always_comb begin
    bad        = 1'b0;
    do_remove  = 1'b0;
    do_insert  = 1'b0;
    key_task   = item_task;
    ins_task_d = item_task;
    ins_prio_d = rd_prio;
    tab_wr_d   = '0;
    if (id_bad) begin
      bad = 1'b1;
    end else begin
      case (item_action)
        prq_pkg::ACT_SETTINGS: begin
          tab_wr_d.rr_we = 1'b1;
          tab_wr_d.rr    = item_rr;
          if (rd_prio != item_prio) begin
            tab_wr_d.prio_we = 1'b1;
            // Move a queued task to where a fresh enqueue would put it
            if (rd_queued) begin
              do_remove  = 1'b1;
              do_insert  = 1'b1;
              ins_prio_d = item_prio;
            end
          end
        end
        prq_pkg::ACT_ENQUEUE: begin
          if (rd_queued || full) begin
            bad = 1'b1;
          end else begin
            do_insert          = 1'b1;
            tab_wr_d.queued_we = 1'b1;
            tab_wr_d.queued    = 1'b1;
          end
        end
        prq_pkg::ACT_REMOVE: begin
          if (!rd_queued) begin
            bad = 1'b1;
          end else begin
            do_remove          = 1'b1;
            tab_wr_d.queued_we = 1'b1;
            tab_wr_d.queued    = 1'b0;
          end
        end
        prq_pkg::ACT_CHANGE: begin
          // A zero priority leaves everything as it is
          if ((item_prio != '0) && (rd_prio != item_prio)) begin
            tab_wr_d.prio_we = 1'b1;
            if (rd_queued) begin
              do_remove  = 1'b1;
              do_insert  = 1'b1;
              ins_prio_d = item_prio;
            end
          end
        end
        prq_pkg::ACT_TICK: begin
          // Rotate a round-robin head behind its equals
          if (head_valid && rd_rr) begin
            do_remove  = 1'b1;
            do_insert  = 1'b1;
            key_task   = head_task;
            ins_task_d = head_task;
          end
        end
        default: begin
          bad = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    tab_wr         = (state == S_REMOVE) ? tab_wr_d : '0;
    cell_op.remove = (state == S_REMOVE) && do_remove;
    cell_op.insert = (state == S_INSERT) && ins_pending;
    count_next     = count;
    if (cell_op.remove) begin
      count_next = count - 1'b1;
    end else if (cell_op.insert) begin
      count_next = count + 1'b1;
    end
  end

  prq_tab #(
    .ID_COUNT      (ID_COUNT),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_tab (
    .clk        (clk),
    .rst        (rst),
    .wr         (tab_wr),
    .idx        (tab_idx),
    .wr_prio    (item_prio),
    .rd_prio    (rd_prio),
    .rd_rr      (rd_rr),
    .rd_queued  (rd_queued),
    .queued_vec (queued_vec)
  );

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic                     prev_valid;
    logic                     prev_keep;
    logic [TW-1:0]            prev_task;
    logic [PRIORITY_BITS-1:0] prev_prio;
    logic                     found_in;
    logic                     next_valid;
    logic [TW-1:0]            next_task;
    logic [PRIORITY_BITS-1:0] next_prio;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b0;
      assign prev_keep  = 1'b1;
      assign prev_task  = '0;
      assign prev_prio  = '0;
      assign found_in   = 1'b0;
    end else begin : g_inner
      assign prev_valid = c_valid[i-1];
      assign prev_keep  = c_keep[i-1];
      assign prev_task  = c_task[i-1];
      assign prev_prio  = c_prio[i-1];
      assign found_in   = c_found[i-1];
    end

    if (i == SLOTS - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_task  = '0;
      assign next_prio  = '0;
    end else begin : g_more
      assign next_valid = c_valid[i+1];
      assign next_task  = c_task[i+1];
      assign next_prio  = c_prio[i+1];
    end

    prq_cell #(
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (cell_op),
      .key_task   (key_task),
      .ins_task   (ins_task),
      .ins_prio   (ins_prio),
      .prev_valid (prev_valid),
      .prev_keep  (prev_keep),
      .prev_task  (prev_task),
      .prev_prio  (prev_prio),
      .found_in   (found_in),
      .next_valid (next_valid),
      .next_task  (next_task),
      .next_prio  (next_prio),
      .slot_valid (c_valid[i]),
      .slot_task  (c_task[i]),
      .slot_prio  (c_prio[i]),
      .keep       (c_keep[i]),
      .found_out  (c_found[i]),
      .valid_next (c_valid_next[i]),
      .task_next  (c_task_next[i])
    );
  end

  // Hold the accepted transaction for the two passes
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_action <= prq_pkg::action_t'(action);
      item_task   <= task_id;
      item_prio   <= PRIORITY_BITS'(priority_req);
      item_rr     <= round_robin;
    end
    if (state == S_REMOVE) begin
      ins_task <= ins_task_d;
      ins_prio <= ins_prio_d;
      bad_q    <= bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ins_pending <= 1'b0;
      count       <= '0;
    end else begin
      count <= count_next;
      if (state == S_REMOVE) begin
        ins_pending <= do_insert;
      end else if (state == S_INSERT) begin
        ins_pending <= 1'b0;
      end
    end
  end

  // Sequencer and result register. The result takes the row's next head, so
  // it sees the insert pass of this cycle; in the hold state the row is still.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && !res_load) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            state <= S_REMOVE;
          end
        end
        S_REMOVE: begin
          state <= S_INSERT;
        end
        S_INSERT, S_HOLD: begin
          if (res_load) begin
            result_valid <= 1'b1;
            current_task <= c_valid_next[0] ? c_task_next[0] : '0;
            queue_length <= prq_pkg::LEN_W'(count_next);
            rejected     <= bad_q;
            state        <= S_IDLE;
          end else begin
            state <= S_HOLD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // Occupied slots always form an unbroken run from the head
  a_slots_packed: assert property (@(posedge clk) disable iff (rst)
    (c_valid & (c_valid + 1'b1)) == '0)
    else $error("slot row has a gap");

  // Slot count tracks the occupied cells
  a_count_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(c_valid) == int'(count))
    else $error("queue count disagrees with slot row");

  // Queued flags agree with the slot count whenever the block is idle
  a_count_flags: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(queued_vec) == int'(count)))
    else $error("queued flags disagree with queue count");

  // A rejected transaction leaves the queue length alone
  a_reject_still: assert property (@(posedge clk) disable iff (rst)
    ((state == S_REMOVE) && bad) |=> ((count == $past(count)) && !ins_pending))
    else $error("rejected transaction changed the queue");

  // An accepted transaction starts the remove pass at once
  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> (state == S_REMOVE))
    else $error("accepted transaction not sequenced");
`endif

endmodule

>>> bench/priority_ready_queue_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the priority ready queue. An initial block builds
// the item list: first a directed run through the corner cases, then random
// episodes that fill, churn and drain the queue. A clocked driver feeds it,
// a clocked monitor checks every result transaction against a scheduler
// predictor that is stepped once per accepted input transaction.
module priority_ready_queue_tb;

  localparam int AW = prq_pkg::ACTION_W;
  localparam int TW = prq_pkg::TASK_W;
  localparam int PW = prq_pkg::PRIO_REQ_W;
  localparam int LW = prq_pkg::LEN_W;
  localparam int PB = prq_pkg::PRIORITY_BITS_DEF;

  localparam int NTASK = prq_pkg::MAX_TASKS_DEF;
  localparam int NSLOT = NTASK - 1;
  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [TW-1:0] KERNEL_TASK = '0;
  // Codes beyond the last action: the block must reject them
  localparam logic [AW-1:0] ACT_RSVD_A = 3'd5;
  localparam logic [AW-1:0] ACT_RSVD_B = 3'd6;
  localparam logic [AW-1:0] ACT_RSVD_C = 3'd7;

  typedef enum int { EP_FILL, EP_CHURN, EP_DRAIN } episode_t;

  typedef struct {
    logic [AW-1:0] act;
    logic [TW-1:0] tid;
    logic [PW-1:0] pri;
    logic          rr;
  } sched_item_t;

  typedef struct {
    logic [TW-1:0] head;
    logic [LW-1:0] len;
    logic          rej;
  } sched_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic          item_valid = 1'b0;
  logic          item_ready;
  logic [AW-1:0] action = '0;
  logic [TW-1:0] task_id = '0;
  logic [PW-1:0] priority_req = '0;
  logic          round_robin = 1'b0;
  logic          result_valid;
  logic          result_ready = 1'b0;
  logic [TW-1:0] current_task;
  logic [LW-1:0] queue_length;
  logic          rejected;

  priority_ready_queue u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .action       (action),
    .task_id      (task_id),
    .priority_req (priority_req),
    .round_robin  (round_robin),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .current_task (current_task),
    .queue_length (queue_length),
    .rejected     (rejected)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Scheduler predictor: its own copy of the slot row and the task table
  // ---------------------------------------------------------------------
  logic [TW-1:0] slot_tid [NSLOT];
  logic [PB-1:0] slot_pri [NSLOT];
  int            occupied;
  logic [PB-1:0] pri_of [NTASK];
  logic          rr_of [NTASK];
  logic          queued_of [NTASK];

  sched_item_t   pending_items[$];
  sched_answer_t answers_due[$];

  // Slot index of a task, or the queue length when it is not queued
  function automatic int slot_of(logic [TW-1:0] t);
    for (int i = 0; i < occupied; i++)
      if (slot_tid[i] == t) return i;
    return occupied;
  endfunction

  // Close the gap left by a slot: everything behind it moves up one
  function automatic void unlink_slot(int pos);
    if (pos >= occupied) return;
    for (int i = pos; i + 1 < occupied; i++) begin
      slot_tid[i] = slot_tid[i+1];
      slot_pri[i] = slot_pri[i+1];
    end
    occupied--;
  endfunction

  // Insert behind every slot of equal or higher priority
  function automatic void link_sorted(logic [TW-1:0] t);
    int pos;
    pos = 0;
    if (occupied >= NSLOT) return;
    while (pos < occupied && slot_pri[pos] >= pri_of[t]) pos++;
    for (int i = occupied; i > pos; i--) begin
      slot_tid[i] = slot_tid[i-1];
      slot_pri[i] = slot_pri[i-1];
    end
    slot_tid[pos] = t;
    slot_pri[pos] = pri_of[t];
    occupied++;
  endfunction

  // A real priority change re-sorts a queued task as if enqueued anew
  function automatic void set_priority(logic [TW-1:0] t, logic [PB-1:0] p);
    if (pri_of[t] == p) return;
    pri_of[t] = p;
    if (queued_of[t]) begin
      unlink_slot(slot_of(t));
      link_sorted(t);
    end
  endfunction

  function automatic sched_answer_t sched_predict(sched_item_t it);
    sched_answer_t ans;
    logic bad;
    logic [TW-1:0] h;
    // Kernel task and ids beyond the table are off limits except for tick
    bad = (it.act <= prq_pkg::ACT_CHANGE) &&
          ((it.tid == KERNEL_TASK) || (int'(it.tid) >= NTASK));
    if (!bad) begin
      case (it.act)
        prq_pkg::ACT_SETTINGS: begin
          rr_of[it.tid] = it.rr;
          set_priority(it.tid, PB'(it.pri));
        end
        prq_pkg::ACT_ENQUEUE: begin
          if (queued_of[it.tid] || occupied >= NSLOT) begin
            bad = 1'b1;
          end else begin
            link_sorted(it.tid);
            queued_of[it.tid] = 1'b1;
          end
        end
        prq_pkg::ACT_REMOVE: begin
          if (!queued_of[it.tid]) begin
            bad = 1'b1;
          end else begin
            unlink_slot(slot_of(it.tid));
            queued_of[it.tid] = 1'b0;
          end
        end
        prq_pkg::ACT_CHANGE: begin
          // Zero request leaves the priority alone
          if (it.pri != '0) set_priority(it.tid, PB'(it.pri));
        end
        prq_pkg::ACT_TICK: begin
          if (occupied > 0) begin
            h = slot_tid[0];
            if (rr_of[h]) begin
              unlink_slot(0);
              link_sorted(h);
            end
          end
        end
        default: bad = 1'b1;
      endcase
    end
    ans.head = (occupied > 0) ? slot_tid[0] : KERNEL_TASK;
    ans.len  = LW'(occupied);
    ans.rej  = bad;
    return ans;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus generation: a shadow of which tasks sit in the queue lets
  // most items be well formed (enqueue of absent tasks, remove of present)
  // ---------------------------------------------------------------------
  logic gen_queued [NTASK];

  function automatic void push_item(logic [AW-1:0] a, logic [TW-1:0] t,
                                    logic [PW-1:0] p, logic r);
    sched_item_t it;
    it.act = a;
    it.tid = t;
    it.pri = p;
    it.rr  = r;
    pending_items.push_back(it);
    if (t != KERNEL_TASK) begin
      if (a == prq_pkg::ACT_ENQUEUE) gen_queued[t] = 1'b1;
      if (a == prq_pkg::ACT_REMOVE) gen_queued[t] = 1'b0;
    end
  endfunction

  // Random non-kernel task that is (or is not) queued; kernel if none fits
  function automatic logic [TW-1:0] pick_task(logic want_queued);
    int start;
    logic [TW-1:0] t;
    start = int'($urandom_range(1, NSLOT));
    for (int k = 0; k < NSLOT; k++) begin
      t = TW'(((start - 1 + k) % NSLOT) + 1);
      if (gen_queued[t] == want_queued) return t;
    end
    return KERNEL_TASK;
  endfunction

  // Narrow priorities give plenty of ties for the round-robin path
  function automatic logic [PW-1:0] draw_priority();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 50) return PW'($urandom_range(1, 4));
    if (r < 85) return PW'($urandom_range(0, 255));
    if (r < 95) return '1;
    return '0;
  endfunction

  function automatic void push_random(episode_t ep);
    int r;
    int w_enq, w_rem, w_set, w_chg;
    logic [TW-1:0] t;
    r = int'($urandom_range(0, 99));
    // Noise: any code, any task, kernel and reserved actions included
    if (r < 8) begin
      push_item(AW'($urandom_range(0, 7)), TW'($urandom_range(0, 15)), PW'($urandom),
                1'($urandom_range(0, 1)));
      return;
    end
    case (ep)
      EP_FILL:  begin w_enq = 45; w_rem = 5;  w_set = 20; w_chg = 15; end
      EP_CHURN: begin w_enq = 25; w_rem = 20; w_set = 15; w_chg = 15; end
      default:  begin w_enq = 10; w_rem = 45; w_set = 10; w_chg = 15; end
    endcase
    r = int'($urandom_range(0, 99));
    if (r < w_enq) begin
      t = pick_task(1'b0);
      // Queue full: fall back to a double enqueue
      if (t == KERNEL_TASK) t = pick_task(1'b1);
      push_item(prq_pkg::ACT_ENQUEUE, t, PW'($urandom), 1'($urandom_range(0, 1)));
    end else if (r < w_enq + w_rem) begin
      t = pick_task(1'b1);
      // Nothing queued: remove of an absent task
      if (t == KERNEL_TASK) t = TW'($urandom_range(1, NSLOT));
      push_item(prq_pkg::ACT_REMOVE, t, PW'($urandom), 1'($urandom_range(0, 1)));
    end else if (r < w_enq + w_rem + w_set) begin
      push_item(prq_pkg::ACT_SETTINGS, TW'($urandom_range(1, NSLOT)), draw_priority(),
                $urandom_range(0, 9) < 6);
    end else if (r < w_enq + w_rem + w_set + w_chg) begin
      push_item(prq_pkg::ACT_CHANGE, TW'($urandom_range(1, NSLOT)), draw_priority(),
                1'($urandom_range(0, 1)));
    end else begin
      push_item(prq_pkg::ACT_TICK, TW'($urandom_range(0, 15)), PW'($urandom),
                1'($urandom_range(0, 1)));
    end
  endfunction

  // ---------------------------------------------------------------------
  // Driver: present pending transactions with a random gap before each
  // ---------------------------------------------------------------------
  int items_made;
  int items_taken = 0;
  int tx_gap = 0;
  bit tx_burst = 1'b0;

  always @(posedge clk) begin
    sched_item_t it;
    if (rst) begin
      item_valid <= 1'b0;
      tx_gap <= int'($urandom_range(0, 15));
    end else begin
      // Step the predictor on every accepted input transaction
      if (item_valid && item_ready) begin
        it.act = action;
        it.tid = task_id;
        it.pri = priority_req;
        it.rr  = round_robin;
        answers_due.push_back(sched_predict(it));
        items_taken++;
      end
      // Hold the payload while a transaction waits for ready
      if (!item_valid || item_ready) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          item_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          it = pending_items.pop_front();
          item_valid   <= 1'b1;
          action       <= it.act;
          task_id      <= it.tid;
          priority_req <= it.pri;
          round_robin  <= it.rr;
          // Switch now and then between back-to-back stretches and gaps
          if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
          tx_gap <= tx_burst ? 0 : int'($urandom_range(0, 15));
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random back-pressure, compare each result transaction with
  // the oldest answer due
  // ---------------------------------------------------------------------
  int rx_stall = 0;
  bit rx_burst = 1'b0;
  int results_seen = 0;
  int mismatches = 0;

  always @(posedge clk) begin
    sched_answer_t want;
    int nxt;
    if (rst) begin
      result_ready <= 1'b0;
      rx_stall <= int'($urandom_range(0, 15));
    end else begin
      nxt = rx_stall;
      if (result_valid && result_ready) begin
        if (answers_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result %0d: task %0d len %0d rej %0b",
                     results_seen, current_task, queue_length, rejected);
        end else begin
          want = answers_due.pop_front();
          if (current_task !== want.head || queue_length !== want.len ||
              rejected !== want.rej) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"mismatch on result %0d: expected task %0d len %0d rej %0b,",
                        " got task %0d len %0d rej %0b"},
                       results_seen, want.head, want.len, want.rej,
                       current_task, queue_length, rejected);
          end
        end
        results_seen++;
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        nxt = rx_burst ? 0 : int'($urandom_range(0, 15));
      end else if (nxt > 0) begin
        nxt--;
      end
      rx_stall <= nxt;
      result_ready <= (nxt == 0);
    end
  end

  // Watchdog: end a hung run
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Item list, reset and end of run
  // ---------------------------------------------------------------------
  initial begin
    int made;
    episode_t ep;
    int ep_len;
    for (int i = 0; i < NTASK; i++) begin
      pri_of[i] = '0;
      rr_of[i] = 1'b0;
      queued_of[i] = 1'b0;
      gen_queued[i] = 1'b0;
    end
    for (int i = 0; i < NSLOT; i++) begin
      slot_tid[i] = '0;
      slot_pri[i] = '0;
    end
    occupied = 0;

    // Directed: empty tick, kernel task and reserved codes
    push_item(prq_pkg::ACT_TICK, KERNEL_TASK, '0, 1'b0);
    push_item(prq_pkg::ACT_SETTINGS, KERNEL_TASK, '1, 1'b1);
    push_item(prq_pkg::ACT_ENQUEUE, KERNEL_TASK, '0, 1'b0);
    push_item(prq_pkg::ACT_REMOVE, KERNEL_TASK, '0, 1'b0);
    push_item(prq_pkg::ACT_CHANGE, KERNEL_TASK, 8'd5, 1'b0);
    push_item(ACT_RSVD_A, 4'd3, '1, 1'b1);
    push_item(ACT_RSVD_B, 4'd7, '0, 1'b0);
    push_item(ACT_RSVD_C, 4'd15, '1, 1'b1);
    // Top priority pair, one round-robin; lowest task at zero priority
    push_item(prq_pkg::ACT_SETTINGS, 4'd1, '1, 1'b1);
    push_item(prq_pkg::ACT_SETTINGS, 4'd2, '1, 1'b0);
    push_item(prq_pkg::ACT_SETTINGS, 4'd15, '0, 1'b1);
    push_item(prq_pkg::ACT_ENQUEUE, 4'd1, '0, 1'b0);
    push_item(prq_pkg::ACT_ENQUEUE, 4'd2, '0, 1'b0);
    push_item(prq_pkg::ACT_ENQUEUE, 4'd15, '1, 1'b1);
    push_item(prq_pkg::ACT_ENQUEUE, 4'd1, '0, 1'b0);     // double enqueue
    push_item(prq_pkg::ACT_TICK, 4'd9, '0, 1'b0);        // round-robin head rotates
    push_item(prq_pkg::ACT_TICK, 4'd0, '1, 1'b1);        // head without flag stays
    push_item(prq_pkg::ACT_CHANGE, 4'd2, '0, 1'b1);      // zero request, no effect
    push_item(prq_pkg::ACT_CHANGE, 4'd2, '1, 1'b0);      // same priority, no move
    push_item(prq_pkg::ACT_CHANGE, 4'd15, 8'd128, 1'b0); // queued task moves up
    push_item(prq_pkg::ACT_SETTINGS, 4'd1, 8'd7, 1'b1);  // settings re-sort
    push_item(prq_pkg::ACT_CHANGE, 4'd3, 8'd9, 1'b0);    // unqueued task
    push_item(prq_pkg::ACT_REMOVE, 4'd4, '0, 1'b0);      // absent task
    push_item(prq_pkg::ACT_REMOVE, 4'd2, '0, 1'b0);
    push_item(prq_pkg::ACT_SETTINGS, 4'd15, '0, 1'b0);   // back to the tail
    push_item(prq_pkg::ACT_REMOVE, 4'd1, '0, 1'b0);
    push_item(prq_pkg::ACT_REMOVE, 4'd15, '0, 1'b0);

    // Random episodes, each biased to fill, churn or drain the queue
    made = 0;
    while (made < RANDOM_ITEMS) begin
      ep = episode_t'($urandom_range(0, 2));
      ep_len = int'($urandom_range(20, 80));
      for (int k = 0; k < ep_len; k++) push_random(ep);
      made += ep_len;
    end
    items_made = pending_items.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for every input transaction, then for every result
    while (items_taken < items_made) @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    // Give any stray result a chance to show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/prq_pkg.sv
rtl/core/prq_cell.sv
rtl/core/prq_tab.sv
rtl/core/priority_ready_queue.sv
bench/priority_ready_queue_tb.sv
